// File: src/bale_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_pkg
// Shared codes, types and constants of the bounded array list engine.
// ----------------------------------------------------------------------------
package bale_pkg;

  // request codes
  localparam logic [2:0] FN_INSERT   = 3'd0;
  localparam logic [2:0] FN_DELETE   = 3'd1;
  localparam logic [2:0] FN_LOCATE   = 3'd2;
  localparam logic [2:0] FN_RETRIEVE = 3'd3;
  localparam logic [2:0] FN_SORTED   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // cells are searched in groups of this size
  localparam int GRP_SIZE = 16;
  localparam int GRP_IW   = 4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  // registered search result of one group of cells
  typedef struct packed {
    logic        any_eq;
    logic [3:0]  eq_idx;
    logic        any_gt;
    logic [3:0]  gt_idx;
    logic [31:0] rd;
  } grp_res_t;

endpackage

// File: src/bale_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_cell
// One list slot: holds an entry, compares it with the request value and
// takes its neighbor's entry when the list shifts.
// ----------------------------------------------------------------------------
module bale_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  logic                clk,
  input  bale_pkg::cell_op_t  op,
  input  logic [IW-1:0]       k,
  input  logic [CW-1:0]       count,
  input  logic signed [31:0]  value,
  input  logic [3:0]          pos,
  input  logic [31:0]         prev_entry,
  input  logic [31:0]         next_entry,
  output logic [31:0]         entry,
  output logic                eq,
  output logic                gt,
  output logic [31:0]         rd
);

  logic occupied;

  assign occupied = int'(count) > IDX;

  always_ff @(posedge clk) begin
    eq <= occupied && (entry == value);
    gt <= occupied && ($signed(entry) > value);
    rd <= (occupied && int'(pos) == IDX) ? entry : '0;
  end

  always_ff @(posedge clk) begin
    case (op)
      bale_pkg::CELL_INS: begin
        if (IDX > int'(k)) begin
          entry <= prev_entry;
        end else if (IDX == int'(k)) begin
          entry <= value;
        end
      end
      bale_pkg::CELL_DEL: begin
        if (IDX >= int'(k)) begin
          entry <= next_entry;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/bale_grp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_grp
// Priority search over one group of cells: first equal entry, first larger
// entry, and the retrieved entry, all registered.
// ----------------------------------------------------------------------------
module bale_grp (
  input  logic                                   clk,
  input  logic [bale_pkg::GRP_SIZE-1:0]          eq,
  input  logic [bale_pkg::GRP_SIZE-1:0]          gt,
  input  logic [bale_pkg::GRP_SIZE-1:0][31:0]    rd,
  output bale_pkg::grp_res_t                     res
);

  bale_pkg::grp_res_t res_next;

  always_comb begin
    res_next = '0;
    // walk down so the lowest hit wins
    for (int i = bale_pkg::GRP_SIZE - 1; i >= 0; i--) begin
      if (eq[i]) begin
        res_next.any_eq = 1'b1;
        res_next.eq_idx = bale_pkg::GRP_IW'(i);
      end
      if (gt[i]) begin
        res_next.any_gt = 1'b1;
        res_next.gt_idx = bale_pkg::GRP_IW'(i);
      end
    end
    for (int i = 0; i < bale_pkg::GRP_SIZE; i++) begin
      res_next.rd = res_next.rd | rd[i];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// File: src/bounded_array_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_core
// Bounded list of signed 32-bit entries kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// After the request transfer come cell compare, group priority search, group
// select, then apply (shift the cells, update the count, load the result
// register). A new request is taken in the cycle after the previous one has
// been applied, so the core holds one request at a time; a stalled output
// holds the apply step until the result register frees up. Entries are not
// cleared by reset; only slots below the count are ever compared or read.
module bounded_array_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [31:0] value,
  input  logic [3:0]         position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               found,
  output logic [3:0]         index,
  output logic signed [31:0] read_value,
  output logic [4:0]         length
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int GS = bale_pkg::GRP_SIZE;
  localparam int NG = (CAPACITY + GS - 1) / GS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_GRP,
    S_SEL,
    S_APPLY
  } state_t;

  state_t              state;
  logic [2:0]          req_func;
  logic signed [31:0]  req_value;
  logic [3:0]          req_pos;
  logic [CW-1:0]       count;

  logic [31:0]         ent [CAPACITY];
  logic [NG*GS-1:0]    eq_v;
  logic [NG*GS-1:0]    gt_v;
  logic [NG*GS-1:0][31:0] rd_v;
  bale_pkg::grp_res_t  grp [NG];

  // select stage
  logic                loc_hit, loc_hit_next;
  logic [IW-1:0]       loc_idx, loc_idx_next;
  logic                gt_hit, gt_hit_next;
  logic [IW-1:0]       gt_idx, gt_idx_next;
  logic [31:0]         sel_rd, sel_rd_next;

  // apply stage
  bale_pkg::cell_op_t  op;
  logic [IW-1:0]       k;
  logic [CW-1:0]       count_next;
  logic [1:0]          status_next;
  logic                found_next;
  logic [IW-1:0]       index_next;
  logic [31:0]         read_next;
  logic                apply;
  logic [CW+3:0]       pos_x;
  logic [CW+3:0]       cnt_x;
  logic [IW+3:0]       pos_k;
  logic [IW+3:0]       index_x;
  logic [CW+4:0]       length_x;
  logic                full;

  assign in_stall = (state != S_IDLE);
  assign apply    = (state == S_APPLY) && (!out_valid || !out_stall);

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] prev_e;
    logic [31:0] next_e;
    if (i == 0) begin : g_first
      assign prev_e = req_value;
    end else begin : g_mid
      assign prev_e = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_body
      assign next_e = ent[i+1];
    end
    bale_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .k          (k),
      .count      (count),
      .value      (req_value),
      .pos        (req_pos),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (ent[i]),
      .eq         (eq_v[i]),
      .gt         (gt_v[i]),
      .rd         (rd_v[i])
    );
  end

  for (genvar i = CAPACITY; i < NG * GS; i++) begin : g_pad
    assign eq_v[i] = 1'b0;
    assign gt_v[i] = 1'b0;
    assign rd_v[i] = '0;
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    bale_grp u_grp (
      .clk (clk),
      .eq  (eq_v[g*GS +: GS]),
      .gt  (gt_v[g*GS +: GS]),
      .rd  (rd_v[g*GS +: GS]),
      .res (grp[g])
    );
  end

  always_comb begin
    loc_hit_next = 1'b0;
    loc_idx_next = '0;
    gt_hit_next  = 1'b0;
    gt_idx_next  = '0;
    sel_rd_next  = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp[g].any_eq) begin
        loc_hit_next = 1'b1;
        loc_idx_next = IW'(g * GS + int'(grp[g].eq_idx));
      end
      if (grp[g].any_gt) begin
        gt_hit_next = 1'b1;
        gt_idx_next = IW'(g * GS + int'(grp[g].gt_idx));
      end
    end
    for (int g = 0; g < NG; g++) begin
      sel_rd_next = sel_rd_next | grp[g].rd;
    end
  end

  always_ff @(posedge clk) begin
    loc_hit <= loc_hit_next;
    loc_idx <= loc_idx_next;
    gt_hit  <= gt_hit_next;
    gt_idx  <= gt_idx_next;
    sel_rd  <= sel_rd_next;
  end

  always_comb begin
    pos_x       = (CW+4)'(req_pos);
    cnt_x       = (CW+4)'(count);
    pos_k       = (IW+4)'(req_pos);
    full        = (count == CW'(CAPACITY));
    op          = bale_pkg::CELL_HOLD;
    k           = '0;
    count_next  = count;
    status_next = bale_pkg::ST_DONE;
    found_next  = 1'b0;
    index_next  = '0;
    read_next   = '0;
    case (req_func)
      bale_pkg::FN_INSERT: begin
        if (pos_x > cnt_x) begin
          status_next = bale_pkg::ST_RANGE;
        end else if (full) begin
          status_next = bale_pkg::ST_FULL;
        end else begin
          op         = bale_pkg::CELL_INS;
          k          = pos_k[IW-1:0];
          count_next = count + CW'(1);
        end
      end
      bale_pkg::FN_DELETE: begin
        if (pos_x >= cnt_x) begin
          status_next = bale_pkg::ST_RANGE;
        end else begin
          op         = bale_pkg::CELL_DEL;
          k          = pos_k[IW-1:0];
          count_next = count - CW'(1);
        end
      end
      bale_pkg::FN_LOCATE: begin
        found_next = loc_hit;
        index_next = loc_hit ? loc_idx : '0;
      end
      bale_pkg::FN_RETRIEVE: begin
        if (pos_x >= cnt_x) begin
          status_next = bale_pkg::ST_RANGE;
        end else begin
          read_next = sel_rd;
        end
      end
      bale_pkg::FN_SORTED: begin
        if (full) begin
          status_next = bale_pkg::ST_FULL;
        end else begin
          // no larger entry: append at the end
          op         = bale_pkg::CELL_INS;
          k          = gt_hit ? gt_idx : count[IW-1:0];
          index_next = k;
          count_next = count + CW'(1);
        end
      end
      default: begin
      end
    endcase
    if (!apply) begin
      op = bale_pkg::CELL_HOLD;
    end
    index_x  = (IW+4)'(index_next);
    length_x = (CW+5)'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_func  <= func;
            req_value <= value;
            req_pos   <= position;
            state     <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_GRP;
        end
        S_GRP: begin
          state <= S_SEL;
        end
        S_SEL: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (apply) begin
            count      <= count_next;
            out_valid  <= 1'b1;
            status     <= status_next;
            found      <= found_next;
            index      <= index_x[3:0];
            read_value <= read_next;
            length     <= length_x[4:0];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAPACITY)
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CW'(1) || count + CW'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_count_on_apply: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> $past(state == S_APPLY))
    else $error("entry count changed outside apply");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == bale_pkg::ST_FULL) |-> count == CW'(CAPACITY))
    else $error("full status reported on a list that is not full");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && out_valid && out_stall) |=> state == S_APPLY)
    else $error("apply step left while the result register was held");
`endif

endmodule
